// ----- src/elg_pkg.sv -----
// ----------------------------------------------------------------------------
// elg_pkg
// Shared types and constants for the rotated-ellipse glow pipeline.
// ----------------------------------------------------------------------------
package elg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_COS_ANGLE  = 3'd2;
    localparam logic [2:0] REG_SIN_ANGLE  = 3'd3;
    localparam logic [2:0] REG_INV_RA_SQ  = 3'd4;
    localparam logic [2:0] REG_INV_RB_SQ  = 3'd5;
    localparam logic [2:0] REG_RAMP_SCALE = 3'd6;
    localparam logic [2:0] REG_GLOW_EN    = 3'd7;

    // item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_RAMP  = 1'b1;

    // 1.0 in Q.32
    localparam logic [32:0] Q2_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [23:0]        inv_ra_sq;
        logic [23:0]        inv_rb_sq;
        logic [15:0]        ramp_scale;
        logic               glow_enable;
    } t_cfg;

    // fields that ride along the whole pipe
    typedef struct packed {
        logic        op;
        logic [15:0] old_pixel;
        logic [5:0]  ramp_index;
        logic [15:0] ramp_value;
    } t_side;

    typedef struct packed {
        t_side      side;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_pix;

    // truncated squares (Q.10); big flags mark a square of 2^32 or more
    typedef struct packed {
        t_side       side;
        logic [31:0] sq_a;
        logic [31:0] sq_b;
        logic        big_a;
        logic        big_b;
    } t_geo;

    typedef struct packed {
        t_side      side;
        logic       in_ell;
        logic [7:0] ramp_pos;
    } t_qd;

endpackage

// ----- src/elg_geom.sv -----
// ----------------------------------------------------------------------------
// elg_geom
// Offset, rotation, magnitude and square of the local coordinates (4 stages).
// ----------------------------------------------------------------------------
module elg_geom
    import elg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_vld,
    output logic  o_in_rdy,
    input  t_pix  i_in,
    output logic  o_out_vld,
    input  logic  i_out_rdy,
    output t_geo  o_out
);

    logic [3:0] r_vld;
    logic [3:0] en;
    t_side      r_side [4];

    logic signed [16:0] r_u, r_v;
    logic signed [16:0] n_u, n_v;
    logic signed [32:0] r_ucos, r_vsin, r_vcos, r_usin;
    logic signed [32:0] n_lx, n_ly;
    logic [31:0]        r_ma, r_mb;
    logic [32:0]        n_abs_a, n_abs_b;
    logic [63:0]        n_pa, n_pb;
    t_geo               r_out;

    always_comb begin
        en[3] = !r_vld[3] || i_out_rdy;
        for (int k = 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_rdy  = en[0];
    assign o_out_vld = r_vld[3];
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_vld;
            end
            for (int k = 1; k < 4; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // pixel centre in Q.4 minus ellipse centre
    assign n_u = $signed({3'b000, i_in.pixel_x, 4'b1000})
               - $signed({i_cfg.center_x[15], i_cfg.center_x});
    assign n_v = $signed({3'b000, i_in.pixel_y, 4'b1000})
               - $signed({i_cfg.center_y[15], i_cfg.center_y});

    assign n_lx = r_ucos + r_vsin;
    assign n_ly = r_vcos - r_usin;
    assign n_abs_a = n_lx[32] ? 33'(-n_lx) : 33'(n_lx);
    assign n_abs_b = n_ly[32] ? 33'(-n_ly) : 33'(n_ly);

    assign n_pa = 64'(r_ma) * 64'(r_ma);
    assign n_pb = 64'(r_mb) * 64'(r_mb);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= i_in.side;
            r_u       <= n_u;
            r_v       <= n_v;
        end
        if (en[1]) begin
            r_side[1] <= r_side[0];
            r_ucos    <= r_u * $signed(i_cfg.cos_angle);
            r_vsin    <= r_v * $signed(i_cfg.sin_angle);
            r_vcos    <= r_v * $signed(i_cfg.cos_angle);
            r_usin    <= r_u * $signed(i_cfg.sin_angle);
        end
        if (en[2]) begin
            r_side[2] <= r_side[1];
            r_ma      <= n_abs_a[31:0];
            r_mb      <= n_abs_b[31:0];
        end
        if (en[3]) begin
            r_out.side  <= r_side[2];
            r_out.sq_a  <= n_pa[57:26];
            r_out.sq_b  <= n_pb[57:26];
            r_out.big_a <= |n_pa[63:58];
            r_out.big_b <= |n_pb[63:58];
        end
    end

endmodule

// ----- src/elg_quad.sv -----
// ----------------------------------------------------------------------------
// elg_quad
// Weighted sum q2, inside test and ramp position (3 stages).
// ----------------------------------------------------------------------------
module elg_quad
    import elg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_vld,
    output logic  o_in_rdy,
    input  t_geo  i_in,
    output logic  o_out_vld,
    input  logic  i_out_rdy,
    output t_qd   o_out
);

    logic [2:0] r_vld;
    logic [2:0] en;
    t_side      r_side [3];

    logic [55:0] n_wa, n_wb;
    logic [31:0] r_wa, r_wb;
    logic        r_over;
    logic [32:0] n_sum;
    logic        r_inside;
    logic [32:0] r_dist;
    logic [48:0] n_scaled;
    t_qd         r_out;

    always_comb begin
        en[2] = !r_vld[2] || i_out_rdy;
        for (int k = 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_rdy  = en[0];
    assign o_out_vld = r_vld[2];
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_vld;
            end
            for (int k = 1; k < 3; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // a square of 2^32 or more is outside unless its weight is zero
    assign n_wa = 56'(i_in.sq_a) * 56'(i_cfg.inv_ra_sq);
    assign n_wb = 56'(i_in.sq_b) * 56'(i_cfg.inv_rb_sq);

    assign n_sum    = {1'b0, r_wa} + {1'b0, r_wb};
    assign n_scaled = 49'(r_dist) * 49'(i_cfg.ramp_scale);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= i_in.side;
            r_wa      <= n_wa[31:0];
            r_wb      <= n_wb[31:0];
            r_over    <= (i_in.big_a && (i_cfg.inv_ra_sq != '0)) || (|n_wa[55:32])
                      || (i_in.big_b && (i_cfg.inv_rb_sq != '0)) || (|n_wb[55:32]);
        end
        if (en[1]) begin
            r_side[1] <= r_side[0];
            r_inside  <= i_cfg.glow_enable && !r_over && !n_sum[32];
            r_dist    <= Q2_ONE - n_sum;
        end
        if (en[2]) begin
            r_out.side     <= r_side[1];
            r_out.in_ell   <= r_inside;
            r_out.ramp_pos <= n_scaled[47:40];
        end
    end

endmodule

// ----- src/elg_ramp.sv -----
// ----------------------------------------------------------------------------
// elg_ramp
// Colour ramp memory, ramp loads in stream order, and the output register.
// ----------------------------------------------------------------------------
module elg_ramp
    import elg_pkg::*;
#(
    parameter int RAMP_ENTRIES = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_vld,
    output logic        o_in_rdy,
    input  t_qd         i_in,
    output logic        o_out_vld,
    input  logic        i_out_rdy,
    output logic [15:0] o_new_pixel,
    output logic        o_inside
);

    localparam int IW = (RAMP_ENTRIES > 1) ? $clog2(RAMP_ENTRIES) : 1;

    logic [15:0]   r_mem [RAMP_ENTRIES];
    logic [1:0]    r_vld;
    logic [1:0]    en;
    logic          acc;
    logic [31:0]   pos_ext;
    logic [31:0]   pos_sel;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_ok;
    logic [15:0]   r_rdata;
    logic [15:0]   r_old;
    logic          r_inside;
    logic [15:0]   r_new_pixel;
    logic          r_out_inside;

    assign en[1] = !r_vld[1] || i_out_rdy;
    assign en[0] = !r_vld[0] || en[1];

    assign o_in_rdy    = en[0];
    assign acc         = i_in_vld && en[0];
    assign o_out_vld   = r_vld[1];
    assign o_new_pixel = r_new_pixel;
    assign o_inside    = r_out_inside;

    // clamp to the last entry
    assign pos_ext = 32'(i_in.ramp_pos);
    assign pos_sel = (pos_ext > 32'(RAMP_ENTRIES - 1)) ? 32'(RAMP_ENTRIES - 1) : pos_ext;
    assign rd_addr = pos_sel[IW-1:0];
    assign wr_addr = IW'(i_in.side.ramp_index);
    assign wr_ok   = 32'(i_in.side.ramp_index) < 32'(RAMP_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                // ramp loads end here, they give no result
                r_vld[0] <= i_in_vld && (i_in.side.op == OP_PIXEL);
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // load and lookup in the same stage keep the stream order
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (i_in.side.op == OP_RAMP) begin
                if (wr_ok) begin
                    r_mem[wr_addr] <= i_in.side.ramp_value;
                end
            end else begin
                r_rdata <= r_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_old    <= i_in.side.old_pixel;
            r_inside <= i_in.in_ell;
        end
        if (en[1]) begin
            r_new_pixel  <= (r_inside && (r_rdata > r_old)) ? r_rdata : r_old;
            r_out_inside <= r_inside;
        end
    end

endmodule

// ----- src/ellipse_glow_ramp_max_core.sv -----
// ----------------------------------------------------------------------------
// ellipse_glow_ramp_max_core
// Per-pixel glow of a rotated ellipse with a loadable colour ramp.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata: pixel and ramp fields,
//                                               tuser: op
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: new_pixel,
//                                               tuser: inside_res
//  cfg      in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One item per cycle while m_axis_tready does not stall the pipe; nine
//  register stages lie between an accepted input transaction and its result.
//  Ramp loads take one slot and give no result.
//  The stages follow the multiplier chain in order: offset, rotate, magnitude,
//  square, weight, sum, scale, ramp read, output register.
//  Reset clears valid bits, presets configuration; ramp contents are undefined
//  until loaded. A stalled output holds each full stage, bubbles collapse.
// ----------------------------------------------------------------------------
module ellipse_glow_ramp_max_core
    import elg_pkg::*;
#(
    parameter int RAMP_ENTRIES = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [35:20] old_pixel,
    // [41:36] ramp_index, [57:42] ramp_value, [63:58] zero
    input  logic [63:0] s_axis_tdata,
    // [0] op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] new_pixel
    output logic [15:0] m_axis_tdata,
    // [0] inside_res
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cfg r_cfg;
    t_pix pix;
    t_geo geo;
    t_qd  qd;
    logic geo_vld, geo_rdy;
    logic qd_vld, qd_rdy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= 16'sd0;
            r_cfg.center_y    <= 16'sd0;
            r_cfg.cos_angle   <= 16'sd16384;
            r_cfg.sin_angle   <= 16'sd0;
            r_cfg.inv_ra_sq   <= 24'd4194304;
            r_cfg.inv_rb_sq   <= 24'd4194304;
            r_cfg.ramp_scale  <= 16'd16384;
            r_cfg.glow_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CENTER_X:   r_cfg.center_x    <= i_cfg_data[15:0];
                REG_CENTER_Y:   r_cfg.center_y    <= i_cfg_data[15:0];
                REG_COS_ANGLE:  r_cfg.cos_angle   <= i_cfg_data[15:0];
                REG_SIN_ANGLE:  r_cfg.sin_angle   <= i_cfg_data[15:0];
                REG_INV_RA_SQ:  r_cfg.inv_ra_sq   <= i_cfg_data;
                REG_INV_RB_SQ:  r_cfg.inv_rb_sq   <= i_cfg_data;
                REG_RAMP_SCALE: r_cfg.ramp_scale  <= i_cfg_data[15:0];
                REG_GLOW_EN:    r_cfg.glow_enable <= i_cfg_data[0];
            endcase
        end
    end

    assign pix.pixel_x         = s_axis_tdata[9:0];
    assign pix.pixel_y         = s_axis_tdata[19:10];
    assign pix.side.old_pixel  = s_axis_tdata[35:20];
    assign pix.side.ramp_index = s_axis_tdata[41:36];
    assign pix.side.ramp_value = s_axis_tdata[57:42];
    assign pix.side.op         = s_axis_tuser;

    elg_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .i_in      (pix),
        .o_out_vld (geo_vld),
        .i_out_rdy (geo_rdy),
        .o_out     (geo)
    );

    elg_quad u_quad (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_vld  (geo_vld),
        .o_in_rdy  (geo_rdy),
        .i_in      (geo),
        .o_out_vld (qd_vld),
        .i_out_rdy (qd_rdy),
        .o_out     (qd)
    );

    elg_ramp #(
        .RAMP_ENTRIES (RAMP_ENTRIES)
    ) u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (qd_vld),
        .o_in_rdy    (qd_rdy),
        .i_in        (qd),
        .o_out_vld   (m_axis_tvalid),
        .i_out_rdy   (m_axis_tready),
        .o_new_pixel (m_axis_tdata),
        .o_inside    (m_axis_tuser)
    );

endmodule

// ----- src/elg_chk.sv -----
// ----------------------------------------------------------------------------
// elg_chk
// Port-level checks on the glow core, bound to the top level.
// ----------------------------------------------------------------------------
module elg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // a stalled result keeps its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output transaction changed under stall");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // with the output side empty nothing can back up to the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // the configuration channel never pushes back
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind ellipse_glow_ramp_max_core elg_chk u_elg_chk (.*);
